FILE: rtl/cntab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting name table package
// Shared field widths, operation and status codes, and the controller states.
// ----------------------------------------------------------------------------
package cntab_pkg;

  localparam int unsigned DefTableDepth = 16;
  localparam int unsigned DefKeyBits    = 64;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned NameW   = 64;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CountW  = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LIST   = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_LIST,
    ST_RESULT
  } state_e;

endpackage

FILE: rtl/cntab_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting name table request channel
// Valid/ready channel that carries one table operation per transfer.
// ----------------------------------------------------------------------------
interface cntab_req_if;
  logic                         valid;
  logic                         ready;
  logic [cntab_pkg::FuncW-1:0]  func;
  logic [cntab_pkg::NameW-1:0]  name_key;
  logic [cntab_pkg::SizeW-1:0]  file_size;

  modport source (output valid, output func, output name_key, output file_size,
                  input ready);
  modport sink   (input valid, input func, input name_key, input file_size,
                  output ready);
endinterface

FILE: rtl/cntab_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting name table response channel
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface cntab_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cntab_pkg::StatusW-1:0]  status;
  logic [cntab_pkg::IndexW-1:0]   entry_index;
  logic [cntab_pkg::NameW-1:0]    entry_name;
  logic [cntab_pkg::SizeW-1:0]    entry_size;
  logic [cntab_pkg::CountW-1:0]   entry_count;
  logic                           last;

  modport source (output valid, output status, output entry_index, output entry_name,
                  output entry_size, output entry_count, output last, input ready);
  modport sink   (input valid, input status, input entry_index, input entry_name,
                  input entry_size, input entry_count, input last, output ready);
endinterface

FILE: rtl/cntab_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting name table storage
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module cntab_ram #(
  parameter  int unsigned Depth = 16,
  parameter  int unsigned Width = 96,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/compacting_name_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting name table unit
// Dense ordered table of (name key, size) entries with create, delete and list.
// ----------------------------------------------------------------------------
// The request channel req_i carries one operation per transfer: create appends
// an entry, delete removes the first entry with a matching key and closes the
// gap, and list returns every entry in order. The response channel rsp_o
// carries the results; the final result of each operation has last set.
// A create writes its entry, if there is room, at the transfer and gives its
// single result through ST_RESULT and then the output register. A delete
// scans the table one entry per cycle and then moves each later entry down
// one place per cycle. A list reads one entry at a time and loads it into the
// output register before it reads the next one. All of this is set by the
// single read port of the table RAM.
// One operation is in progress at a time; the request side is ready again
// as soon as the last result is in the output register.
// Reset empties the table at once; the RAM itself is not cleared.
// When the receiver stalls, the output register holds its result and the
// controller waits before producing the next one; nothing is dropped.
// ----------------------------------------------------------------------------
module compacting_name_table_unit #(
  parameter int unsigned TableDepth = cntab_pkg::DefTableDepth,
  parameter int unsigned KeyBits    = cntab_pkg::DefKeyBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cntab_req_if.sink     req_i,
  cntab_rsp_if.source   rsp_o
);

  import cntab_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned RowW  = KeyBits + SizeW;
  localparam logic [CntW-1:0] DepthCnt = CntW'(TableDepth);

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     ptr_q, ptr_d;
  logic                rvld_q, rvld_d;
  logic [AddrW-1:0]    ridx_q;
  logic [KeyBits-1:0]  key_q;
  status_e             res_status_q, res_status_d;
  logic [AddrW-1:0]    res_index_q, res_index_d;

  logic                out_vld_q, out_vld_d;
  status_e             out_status_q;
  logic [IndexW-1:0]   out_index_q;
  logic [NameW-1:0]    out_name_q;
  logic [SizeW-1:0]    out_size_q;
  logic [CountW-1:0]   out_count_q;
  logic                out_last_q;

  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [RowW-1:0]     wr_data;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;
  logic [RowW-1:0]     rd_data;
  logic [KeyBits-1:0]  rd_key;
  logic [SizeW-1:0]    rd_size;

  logic                in_ready;
  logic                out_free;
  logic                load_list;
  logic                load_res;
  logic                list_last;

  cntab_ram #(
    .Depth (TableDepth),
    .Width (RowW)
  ) u_cntab_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_key    = rd_data[RowW-1:SizeW];
  assign rd_size   = rd_data[SizeW-1:0];
  assign out_free  = !out_vld_q || rsp_o.ready;
  assign list_last = (CntW'(ridx_q) + CntW'(1)) == count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    rvld_d       = 1'b0;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    wr_en        = 1'b0;
    wr_addr      = count_q[AddrW-1:0];
    wr_data      = {req_i.name_key[KeyBits-1:0], req_i.file_size};
    rd_en        = 1'b0;
    rd_addr      = ptr_q[AddrW-1:0];
    in_ready     = 1'b0;
    load_list    = 1'b0;
    load_res     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (req_i.valid) begin
          ptr_d = '0;
          unique case (func_e'(req_i.func))
            FUNC_CREATE: begin
              state_d = ST_RESULT;
              if (count_q < DepthCnt) begin
                wr_en        = 1'b1;
                count_d      = count_q + CntW'(1);
                res_status_d = STAT_OK;
                res_index_d  = count_q[AddrW-1:0];
              end else begin
                res_status_d = STAT_FULL;
                res_index_d  = '0;
              end
            end
            FUNC_DELETE: begin
              if (count_q == '0) begin
                res_status_d = STAT_NOT_FOUND;
                res_index_d  = '0;
                state_d      = ST_RESULT;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            FUNC_LIST: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
                res_index_d  = '0;
                state_d      = ST_RESULT;
              end else begin
                state_d = ST_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (rvld_q && (rd_key == key_q)) begin
          res_status_d = STAT_OK;
          res_index_d  = ridx_q;
          ptr_d        = CntW'(ridx_q) + CntW'(1);
          state_d      = ST_SHIFT;
        end else if (ptr_q < count_q) begin
          rd_en  = 1'b1;
          rvld_d = 1'b1;
          ptr_d  = ptr_q + CntW'(1);
        end else if (!rvld_q) begin
          res_status_d = STAT_NOT_FOUND;
          res_index_d  = '0;
          state_d      = ST_RESULT;
        end
      end

      ST_SHIFT: begin
        if (rvld_q) begin
          wr_en   = 1'b1;
          wr_addr = ridx_q - AddrW'(1);
          wr_data = rd_data;
        end
        if (ptr_q < count_q) begin
          rd_en  = 1'b1;
          rvld_d = 1'b1;
          ptr_d  = ptr_q + CntW'(1);
        end else if (!rvld_q) begin
          count_d = count_q - CntW'(1);
          state_d = ST_RESULT;
        end
      end

      ST_LIST: begin
        if (rvld_q) begin
          load_list = 1'b1;
          if (list_last) begin
            state_d = ST_IDLE;
          end
        end else if ((ptr_q < count_q) && out_free) begin
          rd_en  = 1'b1;
          rvld_d = 1'b1;
          ptr_d  = ptr_q + CntW'(1);
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          load_res = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q && !rsp_o.ready;
    if (load_list || load_res) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    if (rd_en) begin
      ridx_q <= rd_addr;
    end
    if (in_ready && req_i.valid) begin
      key_q <= req_i.name_key[KeyBits-1:0];
    end
    if (load_list) begin
      out_status_q <= STAT_OK;
      out_index_q  <= IndexW'(ridx_q);
      out_name_q   <= NameW'(rd_key);
      out_size_q   <= rd_size;
      out_count_q  <= CountW'(count_q);
      out_last_q   <= list_last;
    end else if (load_res) begin
      out_status_q <= res_status_q;
      out_index_q  <= IndexW'(res_index_q);
      out_name_q   <= '0;
      out_size_q   <= '0;
      out_count_q  <= CountW'(count_q);
      out_last_q   <= 1'b1;
    end
  end

  assign req_i.ready       = in_ready;
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_index = out_index_q;
  assign rsp_o.entry_name  = out_name_q;
  assign rsp_o.entry_size  = out_size_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.last        = out_last_q;

endmodule

FILE: rtl/cntab_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compacting name table checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module cntab_chk #(
  parameter int unsigned TableDepth = cntab_pkg::DefTableDepth
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [cntab_pkg::StatusW-1:0]  status_i,
  input logic [cntab_pkg::IndexW-1:0]   entry_index_i,
  input logic [cntab_pkg::NameW-1:0]    entry_name_i,
  input logic [cntab_pkg::SizeW-1:0]    entry_size_i,
  input logic [cntab_pkg::CountW-1:0]   entry_count_i,
  input logic                           last_i
);

  import cntab_pkg::*;

  // A stalled result must stay in place until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({status_i, entry_index_i, entry_name_i, entry_size_i, entry_count_i, last_i}))
    else $error("response changed while stalled");

  // A full report only happens with every entry in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STAT_FULL) |->
      (entry_count_i == CountW'(TableDepth)) && last_i && (entry_name_i == '0) &&
      (entry_size_i == '0))
    else $error("full report with a table that is not full");

  // An empty report only happens on an empty table and ends the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STAT_EMPTY) |-> (entry_count_i == '0) && last_i &&
      (entry_index_i == '0))
    else $error("empty report with entries present");

  // A failed delete gives a single, cleared result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STAT_NOT_FOUND) |-> last_i && (entry_index_i == '0) &&
      (entry_name_i == '0) && (entry_size_i == '0))
    else $error("malformed not-found result");

endmodule

bind compacting_name_table_unit cntab_chk #(
  .TableDepth (TableDepth)
) u_cntab_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .entry_index_i (rsp_o.entry_index),
  .entry_name_i  (rsp_o.entry_name),
  .entry_size_i  (rsp_o.entry_size),
  .entry_count_i (rsp_o.entry_count),
  .last_i        (rsp_o.last)
);
